>>> rtl/core/kta_pkg.sv
// Shared constants and types for the key-to-allocation hash map.
package kta_pkg;

   localparam int DEFAULT_TABLE_SLOTS = 1024;

   localparam int KEY_W   = 64;
   localparam int BYTES_W = 64;
   localparam int DEV_W   = 4;
   localparam int COUNT_W = 64;
   localparam int HALF_W  = 32;

   localparam logic [KEY_W-1:0] KEY_EMPTY = '0;
   localparam logic [KEY_W-1:0] KEY_DEAD  = '1;
   localparam logic [KEY_W-1:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

   typedef enum logic [0:0] {
      OP_RECORD = 1'b0,
      OP_TAKE   = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      STATUS_STORED   = 3'd0,
      STATUS_RESERVED = 3'd1,
      STATUS_FULL     = 3'd2,
      STATUS_TAKEN    = 3'd3,
      STATUS_MISSING  = 3'd4
   } status_type;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b000_0001,
      ST_IDLE  = 7'b000_0010,
      ST_MUL   = 7'b000_0100,
      ST_MOD   = 7'b000_1000,
      ST_READ  = 7'b001_0000,
      ST_CHECK = 7'b010_0000,
      ST_DONE  = 7'b100_0000
   } state_type;

endpackage

>>> rtl/core/key_to_allocation_hash_map.sv
// Top level of the key-to-allocation open-addressing hash map.
//
//   channel | direction | handshake            | beat fields
//   req     | in        | req_valid/req_stall  | type, lookup_key, device_id, byte_count
//   rsp     | out       | rsp_valid/rsp_stall  | status, found_device, found_bytes,
//           |           |                      |   overflow_count
//
// A request is hashed, reduced to a home slot and probed from there, one read and one
// check per slot, before its result; a reserved key skips hash and probe. One 32x32
// multiplier forms the hash over three passes and, when the slot count is not a power
// of two, a reciprocal home reduction over two more; each probe is one read and one check.
// After reset the key store is swept to empty, one slot a cycle, with req_stall high.
// A waiting rsp beat does not block acceptance of the next request, only its result.
module key_to_allocation_hash_map #(
   parameter int TABLE_SLOTS = kta_pkg::DEFAULT_TABLE_SLOTS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_type,
   input  logic [kta_pkg::KEY_W-1:0]    req_lookup_key,
   input  logic [kta_pkg::DEV_W-1:0]    req_device_id,
   input  logic [kta_pkg::BYTES_W-1:0]  req_byte_count,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_status,
   output logic [kta_pkg::DEV_W-1:0]    rsp_found_device,
   output logic [kta_pkg::BYTES_W-1:0]  rsp_found_bytes,
   output logic [kta_pkg::COUNT_W-1:0]  rsp_overflow_count
);

   localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam bit IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
   localparam int PAY_W = kta_pkg::DEV_W + kta_pkg::BYTES_W;
   localparam logic [SLOT_W:0]   SLOTS_C  = (SLOT_W + 1)'(TABLE_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(TABLE_SLOTS - 1);
   localparam logic [kta_pkg::HALF_W-1:0] SLOTS_H = (kta_pkg::HALF_W)'(TABLE_SLOTS);
   localparam logic [kta_pkg::HALF_W-1:0] RECIP =
      (kta_pkg::HALF_W)'((64'd1 << kta_pkg::HALF_W) / TABLE_SLOTS);
   localparam logic [4:0] MUL_LAST = 5'd3;
   localparam logic [4:0] MOD_LAST = 5'd2;

   kta_pkg::state_type  state_ff, state_in;
   kta_pkg::op_type     op_ff, op_in;
   kta_pkg::status_type status_ff, status_in;

   logic [kta_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [kta_pkg::DEV_W-1:0]   dev_ff, dev_in;
   logic [kta_pkg::BYTES_W-1:0] bytes_ff, bytes_in;
   logic [kta_pkg::DEV_W-1:0]   fdev_ff, fdev_in;
   logic [kta_pkg::BYTES_W-1:0] fbytes_ff, fbytes_in;
   logic [kta_pkg::COUNT_W-1:0] dropped_ff, dropped_in;

   logic [kta_pkg::HALF_W-1:0]   acc_ff, acc_in;
   logic [2*kta_pkg::HALF_W-1:0] prod_ff, prod_in;
   logic [kta_pkg::HALF_W-1:0]   mul_a, mul_b;
   logic [4:0]                   cnt_ff, cnt_in;
   logic [SLOT_W-1:0]            idx_ff, idx_in;
   logic [SLOT_W:0]              probe_ff, probe_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   kta_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [kta_pkg::DEV_W-1:0]   rsp_dev_ff, rsp_dev_in;
   logic [kta_pkg::BYTES_W-1:0] rsp_bytes_ff, rsp_bytes_in;
   logic [kta_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                       key_we;
   logic [kta_pkg::KEY_W-1:0]  key_wdata;
   logic [kta_pkg::KEY_W-1:0]  key_rdata;
   logic                       pay_we;
   logic [PAY_W-1:0]           pay_rdata;

   logic [kta_pkg::HALF_W-1:0] mod_rem;
   logic [SLOT_W-1:0] mod_next;
   logic [SLOT_W-1:0] idx_step;
   logic [SLOT_W:0]   probe_step;
   logic              probes_done;
   logic              slot_free;
   logic              req_take;

   // Shared 32x32 multiplier: low x low, high x low, low x high of key and constant;
   // then hash x reciprocal and quotient x slot count for the home reduction.
   always_comb begin
      mul_a = key_ff[kta_pkg::HALF_W-1:0];
      mul_b = kta_pkg::HASH_MULT[kta_pkg::HALF_W-1:0];
      if (state_ff == kta_pkg::ST_MOD) begin
         if (cnt_ff == 5'd0) begin
            mul_a = acc_ff;
            mul_b = RECIP;
         end else begin
            mul_a = prod_ff[2*kta_pkg::HALF_W-1:kta_pkg::HALF_W];
            mul_b = SLOTS_H;
         end
      end else if (cnt_ff == 5'd1) begin
         mul_a = key_ff[kta_pkg::KEY_W-1:kta_pkg::HALF_W];
      end else if (cnt_ff == 5'd2) begin
         mul_b = kta_pkg::HASH_MULT[kta_pkg::KEY_W-1:kta_pkg::HALF_W];
      end
   end

   assign prod_in = (2 * kta_pkg::HALF_W)'(mul_a) * (2 * kta_pkg::HALF_W)'(mul_b);

   // quotient estimate is low by at most one, so one correction step finishes it
   assign mod_rem  = acc_ff - prod_ff[kta_pkg::HALF_W-1:0];
   assign mod_next = (mod_rem >= SLOTS_H) ? SLOT_W'(mod_rem - SLOTS_H)
                                          : SLOT_W'(mod_rem);

   assign idx_step    = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
   assign probe_step  = probe_ff + 1'b1;
   assign probes_done = (probe_step == SLOTS_C);
   assign slot_free   = (key_rdata == kta_pkg::KEY_EMPTY) || (key_rdata == kta_pkg::KEY_DEAD);
   assign req_take    = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      status_in    = status_ff;
      key_in       = key_ff;
      dev_in       = dev_ff;
      bytes_in     = bytes_ff;
      fdev_in      = fdev_ff;
      fbytes_in    = fbytes_ff;
      dropped_in   = dropped_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      probe_in     = probe_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_dev_in   = rsp_dev_ff;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_count_in = rsp_count_ff;
      key_we       = 1'b0;
      key_wdata    = kta_pkg::KEY_EMPTY;
      pay_we       = 1'b0;

      unique case (state_ff)
         kta_pkg::ST_CLEAR: begin
            key_we = 1'b1;
            idx_in = idx_step;
            if (idx_ff == LAST_IDX) begin
               state_in = kta_pkg::ST_IDLE;
            end
         end
         kta_pkg::ST_IDLE: begin
            if (req_take) begin
               op_in     = kta_pkg::op_type'(req_type);
               key_in    = req_lookup_key;
               dev_in    = req_device_id;
               bytes_in  = req_byte_count;
               fdev_in   = '0;
               fbytes_in = '0;
               cnt_in    = '0;
               probe_in  = '0;
               if (req_lookup_key == kta_pkg::KEY_EMPTY
                   || req_lookup_key == kta_pkg::KEY_DEAD) begin
                  status_in = kta_pkg::STATUS_RESERVED;
                  state_in  = kta_pkg::ST_DONE;
               end else begin
                  state_in = kta_pkg::ST_MUL;
               end
            end
         end
         kta_pkg::ST_MUL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'd1) begin
               acc_in = prod_ff[2*kta_pkg::HALF_W-1:kta_pkg::HALF_W];
            end else if (cnt_ff != 5'd0) begin
               acc_in = acc_ff + prod_ff[kta_pkg::HALF_W-1:0];
            end
            if (cnt_ff == MUL_LAST) begin
               cnt_in   = '0;
               idx_in   = '0;
               state_in = kta_pkg::ST_MOD;
            end
         end
         kta_pkg::ST_MOD: begin
            if (IS_POW2) begin
               idx_in   = acc_ff[SLOT_W-1:0];
               state_in = kta_pkg::ST_READ;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == MOD_LAST) begin
                  idx_in   = mod_next;
                  state_in = kta_pkg::ST_READ;
               end
            end
         end
         kta_pkg::ST_READ: begin
            state_in = kta_pkg::ST_CHECK;
         end
         kta_pkg::ST_CHECK: begin
            probe_in = probe_step;
            idx_in   = idx_step;
            state_in = kta_pkg::ST_READ;
            if (op_ff == kta_pkg::OP_RECORD) begin
               if (slot_free) begin
                  key_we    = 1'b1;
                  key_wdata = key_ff;
                  pay_we    = 1'b1;
                  idx_in    = idx_ff;
                  status_in = kta_pkg::STATUS_STORED;
                  state_in  = kta_pkg::ST_DONE;
               end else if (probes_done) begin
                  dropped_in = dropped_ff + 1'b1;
                  status_in  = kta_pkg::STATUS_FULL;
                  state_in   = kta_pkg::ST_DONE;
               end
            end else begin
               if (key_rdata == key_ff) begin
                  key_we    = 1'b1;
                  key_wdata = kta_pkg::KEY_DEAD;
                  idx_in    = idx_ff;
                  fdev_in   = pay_rdata[PAY_W-1:kta_pkg::BYTES_W];
                  fbytes_in = pay_rdata[kta_pkg::BYTES_W-1:0];
                  status_in = kta_pkg::STATUS_TAKEN;
                  state_in  = kta_pkg::ST_DONE;
               end else if (key_rdata == kta_pkg::KEY_EMPTY || probes_done) begin
                  status_in = kta_pkg::STATUS_MISSING;
                  state_in  = kta_pkg::ST_DONE;
               end
            end
         end
         kta_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_dev_in    = fdev_ff;
               rsp_bytes_in  = fbytes_ff;
               rsp_count_in  = dropped_ff;
               state_in      = kta_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kta_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kta_pkg::ST_CLEAR;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         probe_ff     <= '0;
         dropped_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         probe_ff     <= probe_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      status_ff     <= status_in;
      key_ff        <= key_in;
      dev_ff        <= dev_in;
      bytes_ff      <= bytes_in;
      fdev_ff       <= fdev_in;
      fbytes_ff     <= fbytes_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      rsp_status_ff <= rsp_status_in;
      rsp_dev_ff    <= rsp_dev_in;
      rsp_bytes_ff  <= rsp_bytes_in;
      rsp_count_ff  <= rsp_count_in;
   end

   kta_ram #(
      .WIDTH (kta_pkg::KEY_W),
      .DEPTH (TABLE_SLOTS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (idx_ff),
      .wr_data (key_wdata),
      .rd_addr (idx_ff),
      .rd_data (key_rdata)
   );

   kta_ram #(
      .WIDTH (PAY_W),
      .DEPTH (TABLE_SLOTS)
   ) u_pay_ram (
      .clock   (clock),
      .wr_en   (pay_we),
      .wr_addr (idx_ff),
      .wr_data ({dev_ff, bytes_ff}),
      .rd_addr (idx_ff),
      .rd_data (pay_rdata)
   );

   assign req_stall          = (state_ff != kta_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_device   = rsp_dev_ff;
   assign rsp_found_bytes    = rsp_bytes_ff;
   assign rsp_overflow_count = rsp_count_ff;

endmodule

>>> rtl/core/kta_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> test/testbench.sv
// Self-checking testbench for key_to_allocation_hash_map: table mirror, directed and random beats.
package kta_check_pkg;

   localparam int TABLE_SLOTS = kta_pkg::DEFAULT_TABLE_SLOTS;

   typedef struct {
      kta_pkg::status_type status;
      logic [3:0]          device;
      logic [63:0]         bytes;
      logic [63:0]         dropped;
   } reply_type;

   class scoreboard_type;
      logic [63:0] slot_key [TABLE_SLOTS];
      logic [63:0] slot_size [TABLE_SLOTS];
      logic [3:0]  slot_dev [TABLE_SLOTS];
      logic [63:0] drop_count;
      reply_type   expected_replies[$];
      int unsigned mismatch_count;

      function new();
         foreach (slot_key[i]) begin
            slot_key[i]  = kta_pkg::KEY_EMPTY;
            slot_size[i] = '0;
            slot_dev[i]  = '0;
         end
         drop_count     = '0;
         mismatch_count = 0;
      endfunction

      function int unsigned home_of(logic [63:0] key);
         logic [63:0] mixed;
         mixed = key * kta_pkg::HASH_MULT;
         return mixed[63:32] % TABLE_SLOTS;
      endfunction

      function kta_pkg::status_type accept_request(kta_pkg::op_type op, logic [63:0] key,
                                                   logic [3:0] dev, logic [63:0] bytes);
         reply_type   r;
         int unsigned home;
         int unsigned idx;
         r.device = '0;
         r.bytes  = '0;
         if (key == kta_pkg::KEY_EMPTY || key == kta_pkg::KEY_DEAD) begin
            r.status = kta_pkg::STATUS_RESERVED;
         end else if (op == kta_pkg::OP_RECORD) begin
            r.status = kta_pkg::STATUS_FULL;
            home = home_of(key);
            for (int p = 0; p < TABLE_SLOTS; p++) begin
               idx = (home + p) % TABLE_SLOTS;
               if (slot_key[idx] == kta_pkg::KEY_EMPTY || slot_key[idx] == kta_pkg::KEY_DEAD)
               begin
                  slot_key[idx]  = key;
                  slot_size[idx] = bytes;
                  slot_dev[idx]  = dev;
                  r.status = kta_pkg::STATUS_STORED;
                  break;
               end
            end
            if (r.status == kta_pkg::STATUS_FULL) begin
               drop_count++;
            end
         end else begin
            r.status = kta_pkg::STATUS_MISSING;
            home = home_of(key);
            for (int p = 0; p < TABLE_SLOTS; p++) begin
               idx = (home + p) % TABLE_SLOTS;
               if (slot_key[idx] == key) begin
                  r.device = slot_dev[idx];
                  r.bytes  = slot_size[idx];
                  slot_key[idx]  = kta_pkg::KEY_DEAD;
                  slot_size[idx] = '0;
                  slot_dev[idx]  = '0;
                  r.status = kta_pkg::STATUS_TAKEN;
                  break;
               end
               if (slot_key[idx] == kta_pkg::KEY_EMPTY) begin
                  break;
               end
            end
         end
         r.dropped = drop_count;
         expected_replies.push_back(r);
         return r.status;
      endfunction

      function void match_reply(logic [2:0] status, logic [3:0] dev, logic [63:0] bytes,
                                logic [63:0] dropped);
         reply_type r;
         if (expected_replies.size() == 0) begin
            $error("rsp beat with nothing outstanding: status %0d", status);
            mismatch_count++;
            return;
         end
         r = expected_replies.pop_front();
         if (status !== r.status) begin
            $error("status: expected %0d, actual %0d", r.status, status);
            mismatch_count++;
         end
         if (dev !== r.device) begin
            $error("found_device: expected %0d, actual %0d", r.device, dev);
            mismatch_count++;
         end
         if (bytes !== r.bytes) begin
            $error("found_bytes: expected %0h, actual %0h", r.bytes, bytes);
            mismatch_count++;
         end
         if (dropped !== r.dropped) begin
            $error("overflow_count: expected %0d, actual %0d", r.dropped, dropped);
            mismatch_count++;
         end
      endfunction
   endclass
endpackage

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SLOTS  = kta_check_pkg::TABLE_SLOTS;
   localparam int IDLE_LIMIT   = 50000;
   localparam int DRAIN_CYCLES = 2 * TABLE_SLOTS + 64;
   localparam int HOLD_CYCLES  = 1500;
   localparam int HOLD_AFTER   = 200;
   localparam int RANDOM_ITEMS = 200;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_type = 1'b0;
   logic [63:0] req_lookup_key = '0;
   logic [3:0]  req_device_id = '0;
   logic [63:0] req_byte_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_found_device;
   logic [63:0] rsp_found_bytes;
   logic [63:0] rsp_overflow_count;

   kta_check_pkg::scoreboard_type mirror = new();
   logic [63:0]         live_keys[$];
   kta_pkg::status_type last_status;
   int unsigned         burst_left = 0;
   int unsigned         idle_cycles = 0;
   int unsigned         replies_seen = 0;
   int unsigned         hold_left = 0;
   bit                  hold_done = 1'b0;
   stall_mode_type      stall_mode = STALL_NONE;
   int unsigned         mode_left = 0;

   key_to_allocation_hash_map #(.TABLE_SLOTS(TABLE_SLOTS)) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_lookup_key     (req_lookup_key),
      .req_device_id      (req_device_id),
      .req_byte_count     (req_byte_count),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_found_device   (rsp_found_device),
      .rsp_found_bytes    (rsp_found_bytes),
      .rsp_overflow_count (rsp_overflow_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] rand_bytes();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return rand64();
      endcase
   endfunction

   function automatic logic [63:0] key_with_home(int unsigned home, logic [63:0] start);
      logic [63:0] key;
      key = start;
      while (mirror.home_of(key) != home) begin
         key++;
      end
      return key;
   endfunction

   // bursts of beats with random gaps; valid stays up across back-to-back beats
   task automatic send_request(kta_pkg::op_type op, logic [63:0] key, logic [3:0] dev,
                               logic [63:0] bytes);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_type       <= op;
      req_lookup_key <= key;
      req_device_id  <= dev;
      req_byte_count <= bytes;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      last_status = mirror.accept_request(op, key, dev, bytes);
   endtask

   task automatic do_record(logic [63:0] key);
      if (key != kta_pkg::KEY_EMPTY && key != kta_pkg::KEY_DEAD) begin
         live_keys.push_back(key);
      end
      send_request(kta_pkg::OP_RECORD, key, 4'($urandom_range(0, 15)), rand_bytes());
   endtask

   task automatic do_take_known();
      int unsigned idx;
      logic [63:0] key;
      if (live_keys.size() == 0) begin
         key = rand64();
      end else begin
         idx = $urandom_range(0, live_keys.size() - 1);
         key = live_keys[idx];
         live_keys.delete(idx);
      end
      send_request(kta_pkg::OP_TAKE, key, 4'($urandom_range(0, 15)), rand64());
   endtask

   // receiver: stall pattern of its own, plus one long hold-off
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         mirror.match_reply(rsp_status, rsp_found_device, rsp_found_bytes, rsp_overflow_count);
         replies_seen++;
      end
      if (!hold_done && replies_seen >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(32, 400);
      end else begin
         mode_left--;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= mode_left[2];
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         idle_cycles = 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles++;
      end
   end

   initial begin
      logic [63:0] key_a;
      logic [63:0] key_c;
      logic [63:0] key_d;
      logic [63:0] key_w0;
      logic [63:0] key_w1;
      int unsigned pick;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      key_a  = 64'd1;
      key_c  = key_with_home(mirror.home_of(key_a), 64'd2);
      key_d  = key_with_home(mirror.home_of(key_a), key_c + 64'd1);
      key_w0 = key_with_home(TABLE_SLOTS - 1, 64'h100);
      key_w1 = key_with_home(TABLE_SLOTS - 1, key_w0 + 64'd1);

      send_request(kta_pkg::OP_TAKE, 64'd5, 4'hF, '1);
      send_request(kta_pkg::OP_RECORD, kta_pkg::KEY_EMPTY, 4'hA, rand64());
      send_request(kta_pkg::OP_TAKE, kta_pkg::KEY_EMPTY, 4'h5, rand64());
      send_request(kta_pkg::OP_RECORD, kta_pkg::KEY_DEAD, 4'hF, '1);
      send_request(kta_pkg::OP_TAKE, kta_pkg::KEY_DEAD, 4'h0, '0);
      send_request(kta_pkg::OP_RECORD, key_a, 4'h0, '0);
      send_request(kta_pkg::OP_RECORD, 64'hFFFF_FFFF_FFFF_FFFE, 4'hF, '1);
      send_request(kta_pkg::OP_RECORD, key_c, 4'h9, rand64());
      send_request(kta_pkg::OP_RECORD, key_a, 4'h3, rand64());
      send_request(kta_pkg::OP_TAKE, key_a, 4'hF, '1);
      send_request(kta_pkg::OP_TAKE, key_c, 4'h0, rand64());
      send_request(kta_pkg::OP_TAKE, key_a, 4'h7, rand64());
      send_request(kta_pkg::OP_TAKE, key_a, 4'h1, rand64());
      send_request(kta_pkg::OP_TAKE, 64'hFFFF_FFFF_FFFF_FFFE, 4'h0, '0);
      send_request(kta_pkg::OP_RECORD, key_d, 4'h5, rand64());
      send_request(kta_pkg::OP_TAKE, key_d, 4'hC, rand64());
      // two keys homed on the last slot: the second wraps round to the start
      send_request(kta_pkg::OP_RECORD, key_w0, 4'h2, rand64());
      send_request(kta_pkg::OP_RECORD, key_w1, 4'hE, rand64());
      send_request(kta_pkg::OP_TAKE, key_w1, 4'h0, '0);
      send_request(kta_pkg::OP_TAKE, key_w0, 4'h0, '0);
      send_request(kta_pkg::OP_RECORD, 64'h8000_0000_0000_0000, 4'h6,
                   64'h8000_0000_0000_0000);
      send_request(kta_pkg::OP_TAKE, 64'h8000_0000_0000_0000, 4'h0, '0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8 && live_keys.size() != 0) begin
            do_record(live_keys[$urandom_range(0, live_keys.size() - 1)]);
         end else if (pick < 45) begin
            do_record(rand64());
         end else if (pick < 80) begin
            do_take_known();
         end else if (pick < 93) begin
            send_request(kta_pkg::OP_TAKE, rand64(), 4'($urandom_range(0, 15)), rand64());
         end else begin
            send_request(kta_pkg::op_type'($urandom_range(0, 1)),
                         ($urandom_range(0, 1) == 0) ? kta_pkg::KEY_EMPTY : kta_pkg::KEY_DEAD,
                         4'($urandom_range(0, 15)), rand64());
         end
      end

      // fill the table to the brim, then overflow it
      do begin
         do_record(rand64());
      end while (last_status != kta_pkg::STATUS_FULL);
      repeat (3) do_record(rand64());
      repeat (2) send_request(kta_pkg::OP_TAKE, rand64(), 4'($urandom_range(0, 15)), rand64());
      do_take_known();
      do_record(rand64());
      do_record(rand64());

      req_valid <= 1'b0;
      while (mirror.expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mirror.mismatch_count == 0 && mirror.expected_replies.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/kta_pkg.sv
rtl/core/kta_ram.sv
rtl/core/key_to_allocation_hash_map.sv
test/testbench.sv
